FILE: hdl/hpc_pkg.sv
`default_nettype none

package hpc_pkg;

  // Field widths fixed by the stream format.
  localparam int SAMPLE_W   = 16;
  localparam int SLOPE_W    = SAMPLE_W + 1;
  localparam int INDEX_W    = 32;
  localparam int BEAT_W     = 16;
  localparam int THRESH_W   = 21;
  localparam int GAP_W      = 16;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 1;

  // Default half window of the slope line and reset values of the registers.
  localparam int WINDOW_DEF = 15;
  localparam logic [THRESH_W-1:0] PEAK_THRESHOLD_RST = THRESH_W'(40);
  localparam logic [GAP_W-1:0]    MIN_PEAK_GAP_RST   = GAP_W'(40);

  // Depth of the queue between front and back end (power of two).
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEAK_THRESHOLD = 1'b0,
    CFG_MIN_PEAK_GAP   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
  } hpc_in_t;

  typedef struct packed {
    logic                       smoothed_valid;
    logic signed [SAMPLE_W-1:0] smoothed_sample;
    logic                       peak_found;
    logic [INDEX_W-1:0]         peak_index;
    logic                       beat_found;
    logic [BEAT_W-1:0]          beat_count;
  } hpc_out_t;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    logic                       smoothed_valid;
    logic signed [SAMPLE_W-1:0] smoothed_sample;
    logic                       slope_valid;
    logic signed [SLOPE_W-1:0]  slope;
    logic                       check;
    logic [INDEX_W-1:0]         index;
  } hpc_rec_t;

endpackage

`default_nettype wire

FILE: hdl/hpc_in_if.sv
`default_nettype none

interface hpc_in_if;
  logic             valid;
  logic             ready;
  hpc_pkg::hpc_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/hpc_out_if.sv
`default_nettype none

interface hpc_out_if;
  logic              valid;
  logic              ready;
  hpc_pkg::hpc_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/hpc_front.sv
`default_nettype none

// Sample delay line, spike repair and slope forming. One item per accepted sample.
module hpc_front #(
  parameter int WINDOW = hpc_pkg::WINDOW_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               push,
  input  wire logic signed [hpc_pkg::SAMPLE_W-1:0] sample,
  output hpc_pkg::hpc_rec_t                        rec
);

  localparam int SW = hpc_pkg::SAMPLE_W;
  localparam int DW = hpc_pkg::SLOPE_W;
  localparam int IW = hpc_pkg::INDEX_W;
  localparam logic [IW-1:0] CHECK_START = IW'(2 * WINDOW + 3);
  localparam logic [IW-1:0] IDX_OFFSET  = IW'(WINDOW + 2);

  logic signed [SW-1:0] line_r [0:3];
  logic signed [DW-1:0] prev_slope_r;
  logic [IW-1:0]        cnt_r;

  logic signed [SW-1:0] l0, l1, l2, l3, l4, l2_fin;
  logic signed [DW-1:0] dnew;
  logic signed [DW:0]   ddiff;
  logic [DW:0]          mag_diff, mag_prev;
  logic signed [SW+1:0] acc, acc_adj;
  logic                 repair;

  always_comb begin
    l0 = line_r[0];
    l1 = line_r[1];
    l2 = line_r[2];
    l3 = line_r[3];
    l4 = sample;
    dnew = DW'(l2) - DW'(l1);
    ddiff = (DW + 1)'(dnew) - (DW + 1)'(prev_slope_r);
    mag_diff = ddiff[DW] ? (DW + 1)'(-ddiff) : (DW + 1)'(ddiff);
    mag_prev = prev_slope_r[DW-1] ? (DW + 1)'(-(DW + 1)'(prev_slope_r))
                                  : (DW + 1)'(prev_slope_r);
    repair = (cnt_r >= IW'(4)) && (mag_diff > mag_prev);
    acc = (SW + 2)'(l0) + (SW + 2)'(l1) + (SW + 2)'(l3) + (SW + 2)'(l4);
    // Division by four rounds toward zero, so negative sums are biased first.
    acc_adj = acc + (acc[SW+1] ? (SW + 2)'(3) : (SW + 2)'(0));
    l2_fin = repair ? SW'(acc_adj >>> 2) : l2;

    rec.smoothed_valid  = cnt_r >= IW'(2);
    rec.smoothed_sample = rec.smoothed_valid ? l2_fin : '0;
    rec.slope_valid     = cnt_r >= IW'(3);
    rec.slope           = dnew;
    rec.check           = cnt_r >= CHECK_START;
    rec.index           = cnt_r - IDX_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        line_r[k] <= '0;
      end
      prev_slope_r <= '0;
      cnt_r <= '0;
    end else if (push) begin
      line_r[0] <= l1;
      line_r[1] <= l2_fin;
      line_r[2] <= l3;
      line_r[3] <= l4;
      if (rec.slope_valid) begin
        prev_slope_r <= dnew;
      end
      if (cnt_r != '1) begin
        cnt_r <= cnt_r + IW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hpc_queue.sv
`default_nettype none

// Small first-in first-out queue of classified items.
module hpc_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  hpc_pkg::hpc_rec_t push_rec,
  output logic              full,
  input  wire logic         pop,
  output hpc_pkg::hpc_rec_t pop_rec,
  output logic              empty
);

  localparam int DEPTH = hpc_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  hpc_pkg::hpc_rec_t store_r [0:DEPTH-1];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign full    = count_r == CW'(DEPTH);
  assign empty   = count_r == '0;
  assign pop_rec = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hpc_back.sv
`default_nettype none

// Slope line with running window sums, peak test and beat clustering.
module hpc_back #(
  parameter int WINDOW = hpc_pkg::WINDOW_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  hpc_pkg::hpc_rec_t                 q_rec,
  output logic                              q_pop,
  input  wire logic [hpc_pkg::THRESH_W-1:0] peak_threshold,
  input  wire logic [hpc_pkg::GAP_W-1:0]    min_peak_gap,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output hpc_pkg::hpc_out_t                 out_payload
);

  localparam int DW    = hpc_pkg::SLOPE_W;
  localparam int IW    = hpc_pkg::INDEX_W;
  localparam int BW    = hpc_pkg::BEAT_W;
  localparam int TW    = hpc_pkg::THRESH_W;
  localparam int SPAN  = 2 * WINDOW + 1;
  localparam int SUM_W = DW + $clog2(WINDOW + 1);
  localparam int CMP_W = (SUM_W + 1 > TW + 1) ? SUM_W + 1 : TW + 1;

  logic signed [DW-1:0]    slope_r [0:SPAN-1];
  logic signed [SUM_W-1:0] sum_before_r, sum_after_r;
  logic                    a_valid_r;
  hpc_pkg::hpc_rec_t       a_rec_r;

  logic [IW-1:0]           last_peak_r;
  logic                    seen_peak_r;
  logic [BW-1:0]           beats_r;
  logic                    out_valid_r;
  hpc_pkg::hpc_out_t       out_r;

  logic                    adv_out, take_a;
  logic signed [CMP_W-1:0] diff, thr_ext;
  logic                    peak, gap_ok, beat;
  logic [IW:0]             idx_gap;
  logic [BW-1:0]           beats_nxt;

  assign adv_out = !out_valid_r || out_ready;
  assign take_a  = !a_valid_r || adv_out;
  assign q_pop   = !q_empty && take_a;

  always_comb begin
    diff    = CMP_W'(sum_before_r) - CMP_W'(sum_after_r);
    thr_ext = $signed(CMP_W'(peak_threshold));
    peak    = a_rec_r.check && (diff > thr_ext) && (slope_r[WINDOW] == '0);
    idx_gap = {1'b0, a_rec_r.index} - {1'b0, last_peak_r};
    gap_ok  = !idx_gap[IW] && (idx_gap[IW-1:0] >= IW'(min_peak_gap));
    beat    = peak && (!seen_peak_r || gap_ok);
    beats_nxt = (beat && beats_r != '1) ? beats_r + BW'(1) : beats_r;
  end

  // Slope stage: shift the line and keep both window sums current.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SPAN; k++) begin
        slope_r[k] <= '0;
      end
      sum_before_r <= '0;
      sum_after_r  <= '0;
      a_valid_r    <= 1'b0;
    end else if (q_pop) begin
      a_valid_r <= 1'b1;
      if (q_rec.slope_valid) begin
        for (int k = 0; k < SPAN - 1; k++) begin
          slope_r[k] <= slope_r[k+1];
        end
        slope_r[SPAN-1] <= q_rec.slope;
        sum_before_r <= sum_before_r + SUM_W'(slope_r[WINDOW]) - SUM_W'(slope_r[0]);
        sum_after_r  <= sum_after_r + SUM_W'(q_rec.slope) - SUM_W'(slope_r[WINDOW+1]);
      end
    end else if (adv_out) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_rec_r <= q_rec;
    end
  end

  // Result stage: peak decision, beat clustering and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_peak_r <= '0;
      seen_peak_r <= 1'b0;
      beats_r     <= '0;
    end else if (adv_out) begin
      out_valid_r <= a_valid_r;
      if (a_valid_r) begin
        beats_r <= beats_nxt;
        if (peak) begin
          last_peak_r <= a_rec_r.index;
          seen_peak_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && a_valid_r) begin
      out_r.smoothed_valid  <= a_rec_r.smoothed_valid;
      out_r.smoothed_sample <= a_rec_r.smoothed_sample;
      out_r.peak_found      <= peak;
      out_r.peak_index      <= peak ? a_rec_r.index : '0;
      out_r.beat_found      <= beat;
      out_r.beat_count      <= beats_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

FILE: hdl/heartbeat_peak_counter.sv
// Streaming heart-beat counter. Each input item carries one signed 16-bit sensor
// sample; each one produces exactly one result item, in order, holding the
// smoothed sample leaving the delay line (once two samples have been seen), a
// peak flag with its zero-based index, a beat flag and the saturating beat count.
// Both channels use a valid/ready handshake; an item moves on a rising edge at
// which valid and ready are both high. The user must write configuration
// through cfg_wr_en, cfg_index and cfg_wdata only while the block is idle;
// the block does not enforce this. Index 0 is the peak threshold, index 1 the
// minimum gap between beat clusters. Throughput is one item per clock cycle,
// sustained while out_ch.ready stays high, because the delay lines and the
// running window sums each need only one update per sample. A result passes
// from the queue through the slope stage into the output register.
// Synchronous active-low reset clears the delay lines, slope line, sums,
// counters and handshake state and restores both thresholds to 40.
// When the receiver stalls, the output register holds its item, the slope stage
// and the two-entry queue fill, and only then is in_ch.ready dropped.

`default_nettype none

module heartbeat_peak_counter #(
  parameter int WINDOW = hpc_pkg::WINDOW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  hpc_in_if.sink                              in_ch,
  hpc_out_if.source                           out_ch,
  input  wire logic                           cfg_wr_en,
  input  wire logic [hpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [hpc_pkg::THRESH_W-1:0] peak_threshold_r;
  logic [hpc_pkg::GAP_W-1:0]    min_peak_gap_r;

  logic              push, q_full, q_empty, q_pop;
  hpc_pkg::hpc_rec_t front_rec, queue_rec;

  // Configuration registers; only the low bits that each register holds are kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_threshold_r <= hpc_pkg::PEAK_THRESHOLD_RST;
      min_peak_gap_r   <= hpc_pkg::MIN_PEAK_GAP_RST;
    end else if (cfg_wr_en) begin
      case (hpc_pkg::cfg_reg_t'(cfg_index))
        hpc_pkg::CFG_PEAK_THRESHOLD: begin
          peak_threshold_r <= cfg_wdata[hpc_pkg::THRESH_W-1:0];
        end
        hpc_pkg::CFG_MIN_PEAK_GAP: begin
          min_peak_gap_r <= cfg_wdata[hpc_pkg::GAP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The front end runs whenever the queue has room, so input is held up only
  // once results waiting to be taken have filled the queue.
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  hpc_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .sample (in_ch.payload.sample),
    .rec    (front_rec)
  );

  hpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (front_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (queue_rec),
    .empty    (q_empty)
  );

  hpc_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rec          (queue_rec),
    .q_pop          (q_pop),
    .peak_threshold (peak_threshold_r),
    .min_peak_gap   (min_peak_gap_r),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_payload    (out_ch.payload)
  );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking bench for the heart-beat peak counter.
//
// Samples are queued by the stimulus process and handed to the block by a
// clocked driver. Every item the block accepts is passed at once through a
// cycle-free model of the counter held in this module. That model keeps its
// own copy of the sample and slope delay lines, the sample count, the last
// peak index and the beat tally. Its result is queued. A clocked monitor
// takes each result item the block delivers and compares it, field by field,
// with the oldest queued expectation.
//
// The run has seven stretches:
//   - a short hand-written opening at the reset settings;
//   - six stretches of random traffic, each preceded by new register values.
// Registers are only touched once the block has gone quiet. The register
// values include both ends of each range: a zero threshold with a zero gap,
// and the largest threshold with the largest gap.
// Most random traffic is pulse-shaped: a flat baseline, a steady rise, a short
// plateau and a steady fall. That shape is what lets the slope sums around a
// zero-slope centre clear the threshold. The rest is bursts of raw noise
// across the full sample range.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hpc_pkg::*;

  localparam int SPAN        = 2 * WINDOW_DEF + 1;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hpc_in_if  in_ch ();
  hpc_out_if out_ch ();

  heartbeat_peak_counter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Samples waiting to be offered, and results the block still owes us.
  logic signed [SAMPLE_W-1:0] sample_backlog[$];
  hpc_out_t                   owed_results[$];

  // Idle rates, in percent, for the sender and the receiver.
  int send_idle_pct;
  int recv_idle_pct;

  int fault_count;
  int cycle_count;

  // Register copies and tracker state, mirroring the block after reset.
  logic [THRESH_W-1:0]        thr_copy;
  logic [GAP_W-1:0]           gap_copy;
  logic signed [SAMPLE_W-1:0] smp_line[5];
  logic signed [SLOPE_W-1:0]  slope_line[SPAN];
  logic [INDEX_W-1:0]         samples_seen;
  logic [INDEX_W-1:0]         last_peak_at;
  logic                       had_peak;
  logic [BEAT_W-1:0]          beat_tally;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Prints one line for a failure and counts it.
  task automatic flag_fault(input string msg);
    fault_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v > 32767) begin
      return 16'sd32767;
    end
    if (v < -32768) begin
      return -16'sd32768;
    end
    return SAMPLE_W'(v);
  endfunction

  // Advances the tracker by one accepted sample and returns the result item
  // the block must produce for it.
  function automatic hpc_out_t track_sample(input logic signed [SAMPLE_W-1:0] s);
    hpc_out_t           r;
    logic [INDEX_W-1:0] n;
    logic [INDEX_W-1:0] idx;
    int                 slope_now;
    int                 slope_prev;
    int                 acc;
    longint             sum_before;
    longint             sum_after;
    bit                 is_beat;
    r = '0;
    n = samples_seen;
    for (int k = 0; k < 4; k++) begin
      smp_line[k] = smp_line[k+1];
    end
    smp_line[4] = s;

    if (n >= 3) begin
      // The slope is taken on the original newer sample against the final
      // older one, before any spike repair of the newer sample.
      slope_now = int'(smp_line[2]) - int'(smp_line[1]);
      if (n >= 4) begin
        slope_prev = int'(slope_line[SPAN-1]);
        if (magnitude(slope_now - slope_prev) > magnitude(slope_prev)) begin
          // Spike: replace the middle sample by the mean of its neighbours,
          // truncated toward zero.
          acc = int'(smp_line[0]) + int'(smp_line[1]) + int'(smp_line[3]) +
                int'(smp_line[4]);
          smp_line[2] = SAMPLE_W'(acc / 4);
        end
      end
      for (int k = 0; k < SPAN - 1; k++) begin
        slope_line[k] = slope_line[k+1];
      end
      slope_line[SPAN-1] = SLOPE_W'(slope_now);

      // Once the slope line is full, the centre slope is judged against the
      // slopes either side of it.
      if (n >= 3 + 2 * WINDOW_DEF) begin
        sum_before = 0;
        sum_after  = 0;
        for (int k = 0; k < WINDOW_DEF; k++) begin
          sum_before += longint'(slope_line[k]);
          sum_after  += longint'(slope_line[WINDOW_DEF + 1 + k]);
        end
        if ((sum_before - sum_after > longint'(thr_copy)) &&
            (slope_line[WINDOW_DEF] == '0)) begin
          idx = n - 2 - WINDOW_DEF;
          // A peak opens a new cluster when it is the first one, or when it
          // lies far enough past the previous peak.
          is_beat = !had_peak ||
                    ((idx >= last_peak_at) && ((idx - last_peak_at) >= gap_copy));
          r.peak_found = 1'b1;
          r.peak_index = idx;
          if (is_beat) begin
            r.beat_found = 1'b1;
            if (beat_tally != '1) begin
              beat_tally++;
            end
          end
          last_peak_at = idx;
          had_peak     = 1'b1;
        end
      end
    end

    if (n >= 2) begin
      r.smoothed_valid  = 1'b1;
      r.smoothed_sample = smp_line[2];
    end
    r.beat_count = beat_tally;

    if (samples_seen != '1) begin
      samples_seen++;
    end
    return r;
  endfunction

  // Driver. The prediction is made on the edge that moves the item, and the
  // next item is chosen on that same edge, so valid is never lowered and
  // raised in one step.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        owed_results.push_back(track_sample(in_ch.payload.sample));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid          <= 1'b1;
          in_ch.payload.sample <= sample_backlog.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. It also drives ready at random, stalling at the current rate.
  always @(posedge clk) begin
    hpc_out_t got;
    hpc_out_t want;
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (owed_results.size() == 0) begin
        flag_fault("result item arrived with nothing expected");
      end else begin
        want = owed_results.pop_front();
        if (got.smoothed_valid !== want.smoothed_valid) begin
          flag_fault($sformatf("smoothed_valid %0b, expected %0b",
                               got.smoothed_valid, want.smoothed_valid));
        end
        if (got.smoothed_sample !== want.smoothed_sample) begin
          flag_fault($sformatf("smoothed_sample %0d, expected %0d",
                               got.smoothed_sample, want.smoothed_sample));
        end
        if (got.peak_found !== want.peak_found) begin
          flag_fault($sformatf("peak_found %0b, expected %0b",
                               got.peak_found, want.peak_found));
        end
        if (got.peak_index !== want.peak_index) begin
          flag_fault($sformatf("peak_index %0d, expected %0d",
                               got.peak_index, want.peak_index));
        end
        if (got.beat_found !== want.beat_found) begin
          flag_fault($sformatf("beat_found %0b, expected %0b",
                               got.beat_found, want.beat_found));
        end
        if (got.beat_count !== want.beat_count) begin
          flag_fault($sformatf("beat_count %0d, expected %0d",
                               got.beat_count, want.beat_count));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Waits until every queued sample has gone in and every result has come out.
  // Each sample yields exactly one result, so nothing is left in flight then.
  task automatic wait_quiet();
    while (sample_backlog.size() > 0 || in_ch.valid || owed_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (which == CFG_PEAK_THRESHOLD) begin
      thr_copy = THRESH_W'(value);
    end else begin
      gap_copy = GAP_W'(value);
    end
  endtask

  // One heart-beat-like pulse: flat baseline with a little jitter, a steady
  // rise, a short plateau (the zero slope a peak needs) and a steady fall.
  task automatic add_pulse(inout int added);
    int level;
    int step;
    int lead;
    int rise;
    int hold;
    int fall;
    level = $urandom_range(0, 4000) - 2000;
    step  = ($urandom_range(0, 7) == 0) ? $urandom_range(1500, 4000)
                                        : $urandom_range(1, 1500);
    lead  = $urandom_range(2, 18);
    rise  = $urandom_range(3, 18);
    hold  = $urandom_range(1, 3);
    fall  = $urandom_range(3, 18);
    for (int k = 0; k < lead; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        sample_backlog.push_back(clamp_sample(level + $urandom_range(0, 2) - 1));
      end else begin
        sample_backlog.push_back(clamp_sample(level));
      end
    end
    for (int k = 0; k < rise; k++) begin
      level = level + step;
      sample_backlog.push_back(clamp_sample(level));
    end
    for (int k = 0; k < hold; k++) begin
      sample_backlog.push_back(clamp_sample(level));
    end
    for (int k = 0; k < fall; k++) begin
      level = level - step;
      sample_backlog.push_back(clamp_sample(level));
    end
    added += lead + rise + hold + fall;
  endtask

  // A short burst of raw samples over the whole range.
  task automatic add_noise(inout int added);
    int len;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      sample_backlog.push_back(SAMPLE_W'($urandom()));
    end
    added += len;
  endtask

  // Settles the block, loads both registers and queues a stretch of traffic.
  task automatic run_stretch(input logic [CFG_DATA_W-1:0] thr,
                             input logic [CFG_DATA_W-1:0] gap,
                             input int                    count);
    int added;
    added = 0;
    wait_quiet();
    write_reg(CFG_PEAK_THRESHOLD, thr);
    write_reg(CFG_MIN_PEAK_GAP, gap);
    while (added < count) begin
      if ($urandom_range(0, 4) == 0) begin
        add_noise(added);
      end else begin
        add_pulse(added);
      end
    end
  endtask

  initial begin
    int opening[24];

    // Opening samples: the first few items exercise the start-up of the delay
    // lines. Full-scale swings give the largest slopes and spike repairs, and
    // the alternating bit patterns toggle every bit of the sample. The small
    // triangle is followed by a closing full-scale step.
    opening = '{0, 0, 32767, -32768, 32767, -32768, -1, 1, 0, 21845, -21846,
                0, 0, 0, 100, 200, 300, 300, 200, 100, -32768, -32768,
                32767, 32767};

    // Everything the block sees is known from time zero.
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_index            = CFG_PEAK_THRESHOLD;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.payload.sample = '0;
    out_ch.ready         = 1'b0;
    fault_count          = 0;
    cycle_count          = 0;

    // The tracker starts from the reset state of the block.
    thr_copy     = PEAK_THRESHOLD_RST;
    gap_copy     = MIN_PEAK_GAP_RST;
    samples_seen = '0;
    last_peak_at = '0;
    had_peak     = 1'b0;
    beat_tally   = '0;
    for (int k = 0; k < 5; k++) begin
      smp_line[k] = '0;
    end
    for (int k = 0; k < SPAN; k++) begin
      slope_line[k] = '0;
    end

    // Sender rarely idle, receiver mostly stalled.
    send_idle_pct = 28;
    recv_idle_pct = 79;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Hand-written opening, at the reset register values.
    foreach (opening[k]) begin
      sample_backlog.push_back(SAMPLE_W'(opening[k]));
    end

    // Zero threshold with zero gap makes every peak a beat. The largest
    // threshold with the largest gap can never be cleared.
    run_stretch('0, '0, 80);
    run_stretch(21'd2097151, 21'd65535, 80);

    // Now the sender idles most of the time and the receiver seldom stalls.
    wait_quiet();
    send_idle_pct = 79;
    recv_idle_pct = 28;
    run_stretch(CFG_DATA_W'($urandom_range(50, 3000)), 21'd1, 80);
    run_stretch(CFG_DATA_W'($urandom_range(0, 500)),
                CFG_DATA_W'($urandom_range(1, 200)), 80);

    // Finally back to back, with no idling on either side.
    wait_quiet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_stretch(21'd40, 21'd40, 80);
    run_stretch(CFG_DATA_W'($urandom_range(0, 2000)),
                CFG_DATA_W'($urandom_range(0, 60)), 80);

    wait_quiet();
    repeat (16) @(posedge clk);
    if (owed_results.size() > 0) begin
      flag_fault($sformatf("%0d result items never arrived", owed_results.size()));
    end
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/hpc_pkg.sv
hdl/hpc_in_if.sv
hdl/hpc_out_if.sv
hdl/hpc_front.sv
hdl/hpc_queue.sv
hdl/hpc_back.sv
hdl/heartbeat_peak_counter.sv
test/tb_top.sv
